// File: rtl/core/fsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_pkg: shared types and constants of the free index stack allocator
// Item layouts for both channels, operation and status codes, and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package fsa_pkg;

  // Field widths fixed by the channel definitions.
  localparam int HANDLE_W = 11;
  localparam int OFFSET_W = 26;
  localparam int SLOTS_W  = 11;
  localparam int BYTES_W  = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 17;

  // Handle value that marks an invalid slot.
  localparam logic [HANDLE_W-1:0] INVALID_HANDLE = 11'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES   = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [SLOTS_W-1:0] SLOTS_RESET = 11'd1024;
  localparam logic [BYTES_W-1:0] BYTES_RESET = 17'd64;

  typedef enum logic [1:0] {
    KIND_OBTAIN   = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_FREE_ALL = 2'd2,
    KIND_ACCESS   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_UNDERFLOW  = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                kind;
    logic [HANDLE_W-1:0]  handle;
  } alloc_req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  slot_index;
    logic [OFFSET_W-1:0]  byte_offset;
    status_t              status;
    logic [HANDLE_W-1:0]  live_count;
  } alloc_rsp_t;

endpackage

// File: rtl/core/free_index_stack_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_index_stack_allocator: slot allocator over a stack of free indices
// Obtain pops a free index, release pushes a handle back, free-all refills
// the stack with the identity sequence, access turns a handle into a byte
// offset. The stack lives in one RAM with a registered read.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------
//   in_     | input     | in_valid / in_stall | alloc_req_t (kind, handle)
//   out_    | output    | out_valid/out_stall | alloc_rsp_t (slot, offset,
//           |           |                     |   status, live count)
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Obtain, release and access step through S_IDLE, where the item is taken,
// and S_EXEC, where the stack RAM returns the entry at the top and the
// result registers. Free-all goes through S_FILL, one RAM write per entry
// of the pool and then a step to leave the fill, then S_EXEC for the result.
// After reset a sweep writes all POOL_DEPTH entries with in_stall high;
// configuration writes are taken at all times.
// A result held by out_stall keeps the next item waiting in its last step.
// ----------------------------------------------------------------------------
module free_index_stack_allocator
  import fsa_pkg::*;
#(
  parameter int POOL_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  alloc_req_t            in_item,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output alloc_rsp_t            out_item,
  // Configuration port
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int PW = (CW > SLOTS_W) ? CW : SLOTS_W;
  localparam int PROD_W = HANDLE_W + BYTES_W;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_FILL,
    S_EXEC
  } state_t;

  state_t               state_r, state_nxt;
  alloc_req_t           req_r, req_nxt;
  logic [CW-1:0]        top_r, top_nxt;
  logic [CW-1:0]        handed_r, handed_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic                 out_valid_r, out_valid_nxt;
  alloc_rsp_t           out_item_r, out_item_nxt;
  logic [SLOTS_W-1:0]   slots_r;
  logic [BYTES_W-1:0]   bytes_r;

  logic [PW-1:0]        slots_ext;
  logic [PW-1:0]        pool;
  logic [PW-1:0]        handle_ext;
  logic [PW-1:0]        top_ext;
  logic                 out_free;
  logic [PROD_W-1:0]    product;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_wdata;
  logic [AW-1:0]        mem_rdata;

  // Free index stack.
  fsa_ram #(
    .WIDTH (AW),
    .DEPTH (POOL_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (top_r[AW-1:0]),
    .rd_data (mem_rdata)
  );

  // Effective pool size saturates at the stack depth.
  assign slots_ext  = PW'(slots_r);
  assign pool       = (slots_ext > PW'(POOL_DEPTH)) ? PW'(POOL_DEPTH) : slots_ext;
  assign handle_ext = PW'(req_r.handle);
  assign top_ext    = PW'(top_r);
  assign product    = PROD_W'(req_r.handle) * PROD_W'(bytes_r);

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  // Sequencer: reset sweep, item capture, free-all fill and commit.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    top_nxt       = top_r;
    handed_nxt    = handed_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = fill_r[AW-1:0];
    mem_wdata     = fill_r[AW-1:0];

    unique case (state_r)
      S_INIT: begin
        mem_we   = 1'b1;
        fill_nxt = fill_r + 1'b1;
        if (fill_r == CW'(POOL_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_item;
          fill_nxt = '0;
          state_nxt = (in_item.kind == KIND_FREE_ALL) ? S_FILL : S_EXEC;
        end
      end
      S_FILL: begin
        if (PW'(fill_r) < pool) begin
          mem_we   = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_item_nxt.slot_index  = INVALID_HANDLE;
          out_item_nxt.byte_offset = '0;
          out_item_nxt.status      = ST_OK;
          unique case (req_r.kind)
            KIND_OBTAIN: begin
              if (top_ext < pool) begin
                out_item_nxt.slot_index = HANDLE_W'(mem_rdata);
                top_nxt = top_r + 1'b1;
                if (handed_r < CW'(POOL_DEPTH)) begin
                  handed_nxt = handed_r + 1'b1;
                end
              end else begin
                out_item_nxt.status = ST_EXHAUSTED;
              end
            end
            KIND_RELEASE: begin
              if (top_r == '0) begin
                out_item_nxt.status = ST_UNDERFLOW;
              end else if (handle_ext >= pool) begin
                out_item_nxt.status = ST_BAD_HANDLE;
              end else begin
                top_nxt   = top_r - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = top_nxt[AW-1:0];
                mem_wdata = AW'(req_r.handle);
                if (handed_r != '0) begin
                  handed_nxt = handed_r - 1'b1;
                end
              end
            end
            KIND_FREE_ALL: begin
              top_nxt    = '0;
              handed_nxt = '0;
            end
            KIND_ACCESS: begin
              if (handle_ext >= pool) begin
                out_item_nxt.status = ST_BAD_HANDLE;
              end else begin
                out_item_nxt.byte_offset = product[OFFSET_W-1:0];
              end
            end
            default: begin
            end
          endcase
          out_item_nxt.live_count = HANDLE_W'(handed_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      top_r       <= '0;
      handed_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      handed_r    <= handed_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    out_item_r <= out_item_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOTS_RESET;
      bytes_r <= BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SLOTS_IN_USE: slots_r <= cfg_data[SLOTS_W-1:0];
        REG_SLOT_BYTES:   bytes_r <= cfg_data[BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/core/fsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_ram: simple dual-port RAM with registered read
// One write port and one read port; read data is registered from the
// read address.
// ----------------------------------------------------------------------------
module fsa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
